// ----- hdl/cvr_pkg.sv -----
package cvr_pkg;

  localparam int TABLE_LEN  = 32;
  localparam int TABLE_FRAC = 40;

  // Micro-rotation angles in degrees, scaled by 2^40 and rounded.
  localparam logic [63:0] ANGLE_TABLE40 [TABLE_LEN] = '{
    64'd49478023249920, 64'd29208526391869, 64'd15432965109789, 64'd7834042338137,
    64'd3932216419764,  64'd1968026857673,  64'd984254221883,   64'd492156797755,
    64'd246082796924,   64'd123041948218,   64'd61520974109,    64'd30761036810,
    64'd15380738307,    64'd7690314178,     64'd3845102113,     64'd1922606032,
    64'd961303016,      64'd480706484,      64'd240353242,      64'd120176621,
    64'd60033335,       64'd30016667,       64'd14953358,       64'd7476679,
    64'd3738340,        64'd1869170,        64'd879609,         64'd439805,
    64'd219902,         64'd109951,         64'd58671,          64'd29335
  };

  // Table angle of one step, rounded half up to the given number of fraction bits.
  function automatic logic [63:0] table_entry(input int idx, input int frac_bits);
    logic [63:0] raw;
    int          sh;
    raw = ANGLE_TABLE40[idx % TABLE_LEN];
    sh  = TABLE_FRAC - frac_bits;
    return (raw + (64'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

// ----- hdl/cordic_vector_rotate_degrees_unit.sv -----
// CORDIC rotator in rotation mode with the target angle given in degrees.
// Input channel s_axis: one item holds a vector (x, y) in 30-bit signed Q1.28 and a target
// angle in degrees with ANGLE_FRAC_BITS fraction bits. Output channel m_axis:
// one item per input item, the rotated vector times the CORDIC gain (about
// 1.6468), in the order the inputs came. For sine and cosine preload x with
// the inverse gain and y with zero.
// There is one register stage per micro-rotation. An accepted item passes
// through the stages in order, and m_axis_tvalid for it rises once it is in
// the last stage, which is the output register. One item can be taken every
// cycle while the receiver does not stall.
// When the receiver stalls, items stay in their stages and empty stages still
// fill, so s_axis_tready drops only once every stage holds an item. Nothing is
// lost or repeated.
// Reset clears all stage valid bits; the block is ready once reset is released.
module cordic_vector_rotate_degrees_unit #(
  parameter int ITERATIONS      = 30,
  parameter int DATA_WIDTH      = 32,
  parameter int ANGLE_FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [29:0] x_in, [59:30] y_in, [91:60] angle_in, [95:92] zero
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] x_out, [63:32] y_out
  output logic [63:0] m_axis_tdata
);
  import cvr_pkg::*;

  localparam int DW = DATA_WIDTH;
  // Residual width: covers the target range and the summed table angles.
  localparam int ZW = (((ANGLE_FRAC_BITS + 10) > 33) ? (ANGLE_FRAC_BITS + 10) : 33) + 1;

  logic signed [29:0]   x_in;
  logic signed [29:0]   y_in;
  logic signed [31:0]   angle_in;
  logic signed [DW-1:0] x_in_w, y_in_w;

  logic                 valid [ITERATIONS+1];
  logic                 ready [ITERATIONS+1];
  logic signed [DW-1:0] xs    [ITERATIONS+1];
  logic signed [DW-1:0] ys    [ITERATIONS+1];
  logic signed [ZW-1:0] zs    [ITERATIONS+1];
  logic [ITERATIONS-1:0] stage_full;

  assign x_in     = s_axis_tdata[29:0];
  assign y_in     = s_axis_tdata[59:30];
  assign angle_in = s_axis_tdata[91:60];

  // Inputs are sign-extended, or wrap when the datapath is narrower.
  assign x_in_w = DW'(x_in);
  assign y_in_w = DW'(y_in);

  assign valid[0]      = s_axis_tvalid;
  assign s_axis_tready = ready[0];
  assign xs[0]         = x_in_w;
  assign ys[0]         = y_in_w;
  assign zs[0]         = ZW'(angle_in);

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
    cvr_rotate_stage #(
      .DW         (DW),
      .ZW         (ZW),
      .SHIFT      (i),
      .STEP_ANGLE (table_entry(i, ANGLE_FRAC_BITS))
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid[i]),
      .ready_o (ready[i]),
      .x_i     (xs[i]),
      .y_i     (ys[i]),
      .z_i     (zs[i]),
      .valid_o (valid[i+1]),
      .ready_i (ready[i+1]),
      .x_o     (xs[i+1]),
      .y_o     (ys[i+1]),
      .z_o     (zs[i+1])
    );
    assign stage_full[i] = valid[i+1];
  end

  assign ready[ITERATIONS] = m_axis_tready;
  assign m_axis_tvalid     = valid[ITERATIONS];
  assign m_axis_tdata      = {32'(ys[ITERATIONS]), 32'(xs[ITERATIONS])};

  // A full pipeline with a stalled receiver must refuse new items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&stage_full && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while every stage is full and the output stalls");

  // An empty first stage always takes an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_full[0] |-> s_axis_tready)
    else $error("input refused although the first stage is empty");

  // An accepted item lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> stage_full[0])
    else $error("accepted item missing from the first stage");

  // With the output register empty, the residual of the last stage is unused;
  // a stalled output holds its item and its residual.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(zs[ITERATIONS]))
    else $error("last stage changed while its item was stalled");

endmodule

// ----- hdl/cvr_rotate_stage.sv -----
module cvr_rotate_stage #(
  parameter int          DW         = 32,
  parameter int          ZW         = 34,
  parameter int          SHIFT      = 0,
  parameter logic [63:0] STEP_ANGLE = 64'd0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [DW-1:0] x_i,
  input  logic signed [DW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic signed [DW-1:0] x_o,
  output logic signed [DW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);
  import cvr_pkg::*;

  localparam logic signed [ZW-1:0] STEP = ZW'(STEP_ANGLE);

  logic                 valid_q;
  logic signed [DW-1:0] x_q, x_d;
  logic signed [DW-1:0] y_q, y_d;
  logic signed [ZW-1:0] z_q, z_d;
  logic signed [DW-1:0] x_sh, y_sh;

  // The stage takes a new item when it is empty or its item moves on.
  assign ready_o = !valid_q || ready_i;

  assign x_sh = x_i >>> SHIFT;
  assign y_sh = y_i >>> SHIFT;

  // The residual holds target minus accumulated angle; a negative residual
  // means the target lies below the accumulated angle.
  always_comb begin
    if (z_i[ZW-1]) begin
      x_d = x_i + y_sh;
      y_d = y_i - x_sh;
      z_d = z_i + STEP;
    end else begin
      x_d = x_i - y_sh;
      y_d = y_i + x_sh;
      z_d = z_i - STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule

// ----- bench/tb.sv -----
module tb;

  localparam int ITERATIONS = 30;
  localparam int ANGLE_FRAC = 24;
  localparam int TABLE_FRAC = 40;
  localparam int DEG        = 1 << ANGLE_FRAC;
  localparam logic signed [29:0] UNIT_Q28 = 30'sd268435456;
  localparam logic signed [29:0] INV_GAIN = 30'sd163008218;

  // Micro-rotation angles in degrees, scaled by 2^40 and rounded.
  localparam longint DEG_TABLE40 [32] = '{
    64'd49478023249920, 64'd29208526391869, 64'd15432965109789, 64'd7834042338137,
    64'd3932216419764,  64'd1968026857673,  64'd984254221883,   64'd492156797755,
    64'd246082796924,   64'd123041948218,   64'd61520974109,    64'd30761036810,
    64'd15380738307,    64'd7690314178,     64'd3845102113,     64'd1922606032,
    64'd961303016,      64'd480706484,      64'd240353242,      64'd120176621,
    64'd60033335,       64'd30016667,       64'd14953358,       64'd7476679,
    64'd3738340,        64'd1869170,        64'd879609,         64'd439805,
    64'd219902,         64'd109951,         64'd58671,          64'd29335
  };

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } rotated_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  rotated_t pending_rotations [$];
  int       items_sent      = 0;
  int       results_checked = 0;
  int       errors          = 0;
  bit       tx_steady       = 1'b0;
  bit       rx_steady       = 1'b0;
  int       rx_stall_left   = 0;

  cordic_vector_rotate_degrees_unit #(
    .ITERATIONS     (ITERATIONS),
    .DATA_WIDTH     (32),
    .ANGLE_FRAC_BITS(ANGLE_FRAC)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 10);
    else return $urandom_range(20, 40);
  endfunction

  // Rotates with a 32-bit datapath; the angle accumulator is kept wide so it never wraps.
  function automatic rotated_t rotate_vector(input logic signed [29:0] xi,
                                             input logic signed [29:0] yi,
                                             input logic signed [31:0] ang);
    logic signed [31:0] xr, yr, xs, ys;
    longint             acc, target, step;
    int                 k;
    rotated_t           r;
    xr     = xi;
    yr     = yi;
    acc    = 0;
    target = ang;
    for (k = 0; k < ITERATIONS; k++) begin
      xs   = xr >>> k;
      ys   = yr >>> k;
      step = (DEG_TABLE40[k & 31] + (longint'(1) << (TABLE_FRAC - ANGLE_FRAC - 1)))
             >>> (TABLE_FRAC - ANGLE_FRAC);
      // A tie between target and accumulated angle rotates counterclockwise.
      if (target < acc) begin
        xr  = xr + ys;
        yr  = yr - xs;
        acc = acc - step;
      end else begin
        xr  = xr - ys;
        yr  = yr + xs;
        acc = acc + step;
      end
    end
    r.x = xr;
    r.y = yr;
    return r;
  endfunction

  function automatic logic [29:0] coord_in_range();
    longint v;
    v = longint'($urandom_range(0, 2 * UNIT_Q28)) - UNIT_Q28;
    return v[29:0];
  endfunction

  function automatic logic [31:0] angle_in_range();
    longint v;
    v = longint'($urandom_range(0, 200 * DEG)) - 100 * DEG;
    return v[31:0];
  endfunction

  task automatic report_mismatch(input string what, input longint want, input longint got);
    $display("MISMATCH result %0d %s: expected %0d, got %0d",
             results_checked, what, want, got);
    errors++;
  endtask

  task automatic send_vector(input logic signed [29:0] xv, input logic signed [29:0] yv,
                             input logic signed [31:0] ang);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, ang, yv, xv};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_rotations.push_back(rotate_vector(xv, yv, ang));
    items_sent++;
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_rotations.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, except during steady stretches.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin : check_results
    rotated_t           want;
    logic signed [31:0] got_x, got_y;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_x = m_axis_tdata[31:0];
      got_y = m_axis_tdata[63:32];
      if (pending_rotations.size() == 0) begin
        report_mismatch("arrived with nothing pending, x_out", 0, got_x);
      end else begin
        want = pending_rotations.pop_front();
        if (got_x !== want.x) report_mismatch("x_out", want.x, got_x);
        if (got_y !== want.y) report_mismatch("y_out", want.y, got_y);
      end
      results_checked++;
    end
  end

  task automatic test_reference_points();
    send_vector(UNIT_Q28, 0, 0);
    send_vector(UNIT_Q28, 0, 90 * DEG);
    send_vector(UNIT_Q28, 0, -90 * DEG);
    send_vector(0, UNIT_Q28, 30 * DEG);
    send_vector(-UNIT_Q28, -UNIT_Q28, -60 * DEG);
    send_vector(0, 0, 17 * DEG);
    // Sine and cosine use: x preloaded with the inverse gain, y zero.
    send_vector(INV_GAIN, 0, 30 * DEG);
    send_vector(INV_GAIN, 0, -45 * DEG);
  endtask

  task automatic test_direction_ties();
    // 45 degrees equals the first table step exactly, so step two sees a tie.
    send_vector(UNIT_Q28, UNIT_Q28, 45 * DEG);
    send_vector(UNIT_Q28, -UNIT_Q28, -45 * DEG);
    send_vector(UNIT_Q28, UNIT_Q28, 1);
    send_vector(UNIT_Q28, UNIT_Q28, -1);
  endtask

  task automatic test_field_extremes();
    send_vector(30'h1FFF_FFFF, 30'h1FFF_FFFF, 100 * DEG);
    send_vector(30'h2000_0000, 30'h2000_0000, -100 * DEG);
    send_vector(30'h1FFF_FFFF, 30'h2000_0000, 32'h7FFF_FFFF);
    send_vector(30'h2000_0000, 30'h1FFF_FFFF, 32'h8000_0000);
    send_vector(-UNIT_Q28, UNIT_Q28, 100 * DEG);
  endtask

  task automatic test_unconverged_angles();
    send_vector(UNIT_Q28, 0, 120 * DEG);
    send_vector(UNIT_Q28, 0, -179 * DEG);
    send_vector(0, UNIT_Q28, 127 * DEG);
  endtask

  task automatic test_random_stream();
    int chunk, n, r;
    for (chunk = 0; chunk < 8; chunk++) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (chunk == 4) begin
        // Let the whole pipeline empty before carrying on.
        idle_input();
        wait_drained();
      end
      for (n = 0; n < 50; n++) begin
        r = $urandom_range(0, 99);
        if (r < 80)
          send_vector(coord_in_range(), coord_in_range(), angle_in_range());
        else if (r < 92)
          send_vector(30'($urandom), 30'($urandom), $urandom);
        else if (r < 96)
          send_vector(INV_GAIN, 0, angle_in_range());
        else
          send_vector(coord_in_range(), coord_in_range(),
                      ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(99 * DEG, 127 * DEG));
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reference_points();
    test_direction_ties();
    test_field_extremes();
    test_unconverged_angles();
    test_random_stream();
    idle_input();
    wait_drained();
    repeat (ITERATIONS + 10) @(posedge clk_i);
    $display("Covered %0d vectors: axes, ties, field extremes, unconverged angles,",
             items_sent);
    $display("random in-range and raw patterns; %0d results checked.", results_checked);
    if (errors == 0 && pending_rotations.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d results outstanding.", pending_rotations.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
